/* rtl/core/vtcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voted threshold crossing detector package
// Shared constants, register indexes and control types.
// ----------------------------------------------------------------------------
package vtcd_pkg;

  localparam int DEF_PAST_SPAN   = 8;
  localparam int DEF_FUTURE_SPAN = 8;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int REQ_W      = 4;
  localparam int MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_REQUIRED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FUTURE_REQUIRED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LENGTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LENGTH  = 3'd6;

  localparam logic [CFG_DATA_W-1:0] RST_THRESHOLD      = 16'd0;
  localparam logic [MODE_W-1:0]     RST_DIRECTION_MODE = 2'd1;
  localparam logic [REQ_W-1:0]      RST_REQUIRED       = 4'd0;
  localparam logic [CFG_DATA_W-1:0] RST_JUMP_LIMIT     = 16'hFFFF;
  localparam logic [CFG_DATA_W-1:0] RST_PULSE_LENGTH   = 16'd150;
  localparam logic [CFG_DATA_W-1:0] RST_TIMEOUT_LENGTH = 16'd30000;

  localparam logic [CFG_DATA_W-1:0] JUMP_NO_LIMIT = 16'hFFFF;

  typedef struct packed {
    logic shift;
    logic compare;
    logic decide;
  } vtcd_cmd_t;

endpackage

/* rtl/core/vtcd_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel that carries one signed sample per item.
// ----------------------------------------------------------------------------
interface vtcd_in_if import vtcd_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/core/vtcd_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Judgement result channel
// Valid/ready channel that carries one judgement per item.
// ----------------------------------------------------------------------------
interface vtcd_out_if import vtcd_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          judged_valid;
  logic                          pulse_start;
  logic                          pulse_end;
  logic signed [SAMPLE_BITS-1:0] level;

  modport source (output valid, output judged_valid, output pulse_start,
                  output pulse_end, output level, input ready);
  modport sink   (input valid, input judged_valid, input pulse_start,
                  input pulse_end, input level, output ready);
endinterface

/* rtl/core/vtcd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector controller
// Sequences shift, compare and decide steps and owns the output valid.
// ----------------------------------------------------------------------------
module vtcd_ctrl import vtcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output vtcd_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.shift   = in_valid && (state_r == S_IDLE);
    cmd.compare = (state_r == S_CMP);
    cmd.decide  = (state_r == S_DEC) && (!out_valid_r || out_ready);
    state_nxt   = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.shift) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (cmd.decide) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.decide) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // A result is never written over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  // An accepted item always moves on to the compare step.
  a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CMP))
    else $error("accepted item did not reach compare step");

endmodule

/* rtl/core/vtcd_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector datapath
// Sample window, configuration, threshold compares, votes and timers.
// ----------------------------------------------------------------------------
module vtcd_dp import vtcd_pkg::*; #(
  parameter int PAST_SPAN   = DEF_PAST_SPAN,
  parameter int FUTURE_SPAN = DEF_FUTURE_SPAN,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vtcd_cmd_t                     cmd,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          judged_valid,
  output logic                          pulse_start,
  output logic                          pulse_end,
  output logic signed [SAMPLE_BITS-1:0] level
);

  localparam int WIN_LEN   = PAST_SPAN + FUTURE_SPAN + 2;
  localparam int JUDGE_POS = PAST_SPAN + 1;
  localparam int FILL_W    = $clog2(WIN_LEN + 1);
  localparam int CW        = (SAMPLE_BITS > CFG_DATA_W) ? SAMPLE_BITS : CFG_DATA_W;
  localparam int DW        = SAMPLE_BITS + 1;
  localparam int JW        = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;
  localparam int VW        = (FILL_W > REQ_W) ? FILL_W : REQ_W;

  logic signed [CFG_DATA_W-1:0]  thr_r;
  logic [MODE_W-1:0]             mode_r;
  logic [REQ_W-1:0]              past_req_r;
  logic [REQ_W-1:0]              fut_req_r;
  logic [CFG_DATA_W-1:0]         jump_r;
  logic [CFG_DATA_W-1:0]         plen_r;
  logic [CFG_DATA_W-1:0]         tout_r;

  logic signed [SAMPLE_BITS-1:0] window_r [WIN_LEN];
  logic [FILL_W-1:0]             fill_r;

  logic [WIN_LEN-1:0]            lt_r, lt_c;
  logic [WIN_LEN-1:0]            gt_r, gt_c;
  logic                          jump_ok_r, jump_ok_c;
  logic                          full_r;
  logic signed [SAMPLE_BITS-1:0] cur_r;

  logic [CFG_DATA_W-1:0]         wait_r, wait_nxt;
  logic [CFG_DATA_W-1:0]         rem_r, rem_nxt;
  logic                          active_r, active_nxt;

  logic                          judged_r, start_r, end_r;
  logic signed [SAMPLE_BITS-1:0] level_r;

  logic                          fire_c, end_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= RST_THRESHOLD;
      mode_r     <= RST_DIRECTION_MODE;
      past_req_r <= RST_REQUIRED;
      fut_req_r  <= RST_REQUIRED;
      jump_r     <= RST_JUMP_LIMIT;
      plen_r     <= RST_PULSE_LENGTH;
      tout_r     <= RST_TIMEOUT_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:       thr_r      <= cfg_wdata;
        REG_DIRECTION_MODE:  mode_r     <= cfg_wdata[MODE_W-1:0];
        REG_PAST_REQUIRED:   past_req_r <= cfg_wdata[REQ_W-1:0];
        REG_FUTURE_REQUIRED: fut_req_r  <= cfg_wdata[REQ_W-1:0];
        REG_JUMP_LIMIT:      jump_r     <= cfg_wdata;
        REG_PULSE_LENGTH:    plen_r     <= cfg_wdata;
        REG_TIMEOUT_LENGTH:  tout_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        window_r[i] <= window_r[i+1];
      end
      window_r[WIN_LEN-1] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.shift && (fill_r != FILL_W'(WIN_LEN))) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  always_comb begin
    logic signed [CW-1:0] thr_ext;
    logic signed [CW-1:0] x;
    logic signed [DW-1:0] step;
    logic [DW-1:0]        mag;
    thr_ext = CW'(thr_r);
    for (int i = 0; i < WIN_LEN; i++) begin
      x       = CW'(window_r[i]);
      lt_c[i] = (x < thr_ext);
      gt_c[i] = (x > thr_ext);
    end
    step      = DW'(window_r[JUDGE_POS]) - DW'(window_r[JUDGE_POS-1]);
    mag       = (step < 0) ? DW'(-step) : DW'(step);
    jump_ok_c = (jump_r == JUMP_NO_LIMIT) || (JW'(mag) <= JW'(jump_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      lt_r      <= lt_c;
      gt_r      <= gt_c;
      jump_ok_r <= jump_ok_c;
      full_r    <= (fill_r == FILL_W'(WIN_LEN));
      cur_r     <= window_r[JUDGE_POS];
    end
  end

  always_comb begin
    logic [VW-1:0]         past_rise, past_fall, fut_rise, fut_fall;
    logic                  rise, fall;
    logic [CFG_DATA_W-1:0] wait_dec;
    past_rise = '0;
    past_fall = '0;
    fut_rise  = '0;
    fut_fall  = '0;
    for (int i = 0; i < PAST_SPAN; i++) begin
      past_rise = past_rise + VW'(lt_r[i]);
      past_fall = past_fall + VW'(gt_r[i]);
    end
    for (int i = JUDGE_POS + 1; i < WIN_LEN; i++) begin
      fut_rise = fut_rise + VW'(!lt_r[i]);
      fut_fall = fut_fall + VW'(!gt_r[i]);
    end
    rise = lt_r[JUDGE_POS-1] && !lt_r[JUDGE_POS] && jump_ok_r
           && (past_rise >= VW'(past_req_r)) && (fut_rise >= VW'(fut_req_r));
    fall = gt_r[JUDGE_POS-1] && !gt_r[JUDGE_POS] && jump_ok_r
           && (past_fall >= VW'(past_req_r)) && (fut_fall >= VW'(fut_req_r));
    wait_dec = (wait_r != '0) ? (wait_r - 1'b1) : '0;
    fire_c   = full_r && (wait_dec == '0) && ((mode_r[0] && rise) || (mode_r[1] && fall));
    end_c      = 1'b0;
    wait_nxt   = wait_r;
    rem_nxt    = rem_r;
    active_nxt = active_r;
    if (full_r) begin
      wait_nxt = wait_dec;
      if (fire_c) begin
        wait_nxt   = tout_r;
        rem_nxt    = plen_r;
        active_nxt = 1'b1;
      end else if (active_r) begin
        if (rem_r > CFG_DATA_W'(1)) begin
          rem_nxt = rem_r - 1'b1;
        end else begin
          rem_nxt    = '0;
          active_nxt = 1'b0;
          end_c      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r   <= '0;
      rem_r    <= '0;
      active_r <= 1'b0;
      judged_r <= 1'b0;
      start_r  <= 1'b0;
      end_r    <= 1'b0;
      level_r  <= '0;
    end else if (cmd.decide) begin
      wait_r   <= wait_nxt;
      rem_r    <= rem_nxt;
      active_r <= active_nxt;
      judged_r <= full_r;
      start_r  <= fire_c;
      end_r    <= end_c;
      level_r  <= full_r ? cur_r : '0;
    end
  end

  assign judged_valid = judged_r;
  assign pulse_start  = start_r;
  assign pulse_end    = end_r;
  assign level        = level_r;

  // An idle pulse holds no remaining count.
  a_idle_pulse_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (rem_r == '0))
    else $error("remaining count left behind by an idle pulse");

  // A result from an unfilled window carries nothing.
  a_unjudged_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !judged_r |-> (!start_r && !end_r && (level_r == '0)))
    else $error("unjudged result carries data");

  // A firing arms the re-enable timer with the timeout.
  a_fire_arms_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decide && fire_c) |=> (wait_r == $past(tout_r)) && active_r)
    else $error("firing did not arm the timers");

endmodule

/* rtl/core/voted_threshold_crossing_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voted threshold crossing detector
// Judges each sample against a threshold with window votes and timers.
// ----------------------------------------------------------------------------
// Each sample goes through a shift step into the window, a compare step
// that registers the parallel threshold compares and the jump check, and
// a decide step that counts the votes, runs the pulse and timeout counters
// and loads the result register, waiting while the output register holds
// a result not yet taken. A new item is accepted while the previous result
// still waits in the output register. Results come one per item; until
// the window holds PAST_SPAN + FUTURE_SPAN + 2 samples, judged_valid is low.
module voted_threshold_crossing_detector import vtcd_pkg::*; #(
  parameter int PAST_SPAN   = DEF_PAST_SPAN,
  parameter int FUTURE_SPAN = DEF_FUTURE_SPAN,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vtcd_in_if.sink               in_chan,
  vtcd_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  vtcd_cmd_t cmd;

  vtcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  vtcd_dp #(
    .PAST_SPAN   (PAST_SPAN),
    .FUTURE_SPAN (FUTURE_SPAN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_sample    (in_chan.sample),
    .judged_valid (out_chan.judged_valid),
    .pulse_start  (out_chan.pulse_start),
    .pulse_end    (out_chan.pulse_end),
    .level        (out_chan.level)
  );

endmodule
